/* design/slbc_pkg.sv */
// Package for the status LED blink controller.
// Holds the event, colour, cue and register index codes and the colour drive table.
// No dependencies.
`default_nettype none

package slbc_pkg;

    // Event codes carried by the action field
    typedef enum logic [2:0] {
        ACT_TICK       = 3'd0,
        ACT_FLAG_WRITE = 3'd1,
        ACT_WARN_BTN   = 3'd2,
        ACT_PAIR_BTN   = 3'd3,
        ACT_CONNECT    = 3'd4,
        ACT_DISCONNECT = 3'd5
    } t_action;

    // LED colour codes
    typedef enum logic [2:0] {
        COL_YELLOW = 3'd0,
        COL_RED    = 3'd1,
        COL_GREEN  = 3'd2,
        COL_PURPLE = 3'd3,
        COL_BLUE   = 3'd4,
        COL_OFF    = 3'd5
    } t_color;

    // Buzzer cue codes
    typedef enum logic [1:0] {
        CUE_NONE       = 2'd0,
        CUE_CONNECT    = 2'd1,
        CUE_DISCONNECT = 2'd2
    } t_cue;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_BLINK_INTERVAL = 2'd0,
        REG_BLINK_PAUSE    = 2'd1,
        REG_PAIR_TIMEOUT   = 2'd2
    } t_reg_index;

    localparam int CfgIndexWidth = 2;
    localparam int CfgDataWidth  = 20;
    localparam int IntervalWidth = 16;
    localparam int TimeoutWidth  = 20;
    localparam int LevelWidth    = 8;

    localparam logic [15:0] RstBlinkInterval = 16'd500;
    localparam logic [15:0] RstBlinkPause    = 16'd3000;
    localparam logic [19:0] RstPairTimeout   = 20'd300000;
    localparam logic [15:0] PairBlinks       = 16'd50000;
    localparam logic [19:0] ElapsedMax       = 20'hFFFFF;
    localparam logic [6:0]  CountMask        = 7'd127;

    typedef struct packed {
        logic [LevelWidth-1:0] red;
        logic [LevelWidth-1:0] green;
        logic [LevelWidth-1:0] blue;
    } t_levels;

    // RGB drive for each colour; codes without a colour drive dark
    function automatic t_levels color_levels(input logic [2:0] color);
        t_levels lv;
        lv = '0;
        case (color)
            COL_RED: begin
                lv.red = 8'd255;
            end
            COL_YELLOW: begin
                lv.red   = 8'd255;
                lv.green = 8'd40;
                lv.blue  = 8'd10;
            end
            COL_GREEN: begin
                lv.green = 8'd255;
            end
            COL_BLUE: begin
                lv.blue = 8'd255;
            end
            COL_PURPLE: begin
                lv.red  = 8'd255;
                lv.blue = 8'd150;
            end
            default: begin
                lv = '0;
            end
        endcase
        return lv;
    endfunction

endpackage

`default_nettype wire

/* design/status_led_blink_controller_top.sv */
// Status LED blink controller, top level.
// Applies one event per transaction to the LED, pairing and link state; uses slbc_pkg.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-------------------------------------
//   in      | input     | i_in_valid / o_in_stall    | i_action, i_flag_value
//   out     | output    | o_out_valid / i_out_stall  | o_*_level, o_advertising, o_sound_cue,
//           |           |                            | o_flag_cleared
//   cfg     | input     | i_cfg_we                   | i_cfg_index, i_cfg_wdata
//
// One transaction per clock while input is not stalled: the state update and the result
// are computed in a single pass and the result appears in the output register in the
// cycle after acceptance. The output register is the only stage; input is stalled only
// while a result waits and i_out_stall is high.
// Synchronous active-low reset restores the register defaults and the power-up state
// (purple colour, LED shown off, nothing blinking).
`default_nettype none

module status_led_blink_controller_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic [2:0]                           i_action,
    input  wire logic [7:0]                           i_flag_value,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic [7:0]                                o_red_level,
    output logic [7:0]                                o_green_level,
    output logic [7:0]                                o_blue_level,
    output logic                                      o_advertising,
    output logic [1:0]                                o_sound_cue,
    output logic                                      o_flag_cleared,
    input  wire logic                                 i_cfg_we,
    input  wire logic [slbc_pkg::CfgIndexWidth-1:0]   i_cfg_index,
    input  wire logic [slbc_pkg::CfgDataWidth-1:0]    i_cfg_wdata
);
    import slbc_pkg::*;

    // Configuration registers
    logic [IntervalWidth-1:0] r_blink_interval;
    logic [IntervalWidth-1:0] r_blink_pause;
    logic [TimeoutWidth-1:0]  r_pair_timeout;

    // Controller state
    logic [2:0]               r_led_color,      n_led_color;
    logic [2:0]               r_shown_color,    n_shown_color;
    logic                     r_blink_active,   n_blink_active;
    logic                     r_led_lit,        n_led_lit;
    logic                     r_warning_active, n_warning_active;
    logic                     r_pairing_active, n_pairing_active;
    logic                     r_link_connected, n_link_connected;
    logic [15:0]              r_blink_target,   n_blink_target;
    logic [15:0]              r_blink_done,     n_blink_done;
    logic [15:0]              r_wait_left,      n_wait_left;
    logic [TimeoutWidth-1:0]  r_pair_elapsed,   n_pair_elapsed;

    // Result register
    logic                     r_out_valid;
    t_levels                  r_levels,         n_levels;
    logic                     r_advertising;
    logic [1:0]               r_sound_cue,      n_sound_cue;
    logic                     r_flag_cleared,   n_flag_cleared;

    logic                     in_accept;
    logic [15:0]              done_inc;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink_interval <= RstBlinkInterval;
            r_blink_pause    <= RstBlinkPause;
            r_pair_timeout   <= RstPairTimeout;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BLINK_INTERVAL: r_blink_interval <= i_cfg_wdata[IntervalWidth-1:0];
                REG_BLINK_PAUSE:    r_blink_pause    <= i_cfg_wdata[IntervalWidth-1:0];
                REG_PAIR_TIMEOUT:   r_pair_timeout   <= i_cfg_wdata[TimeoutWidth-1:0];
                default: begin
                end
            endcase
        end
    end

    // Apply the event, then the LED step, then the pairing timeout
    always_comb begin
        n_led_color      = r_led_color;
        n_shown_color    = r_shown_color;
        n_blink_active   = r_blink_active;
        n_led_lit        = r_led_lit;
        n_warning_active = r_warning_active;
        n_pairing_active = r_pairing_active;
        n_link_connected = r_link_connected;
        n_blink_target   = r_blink_target;
        n_blink_done     = r_blink_done;
        n_wait_left      = r_wait_left;
        n_pair_elapsed   = r_pair_elapsed;
        n_sound_cue      = CUE_NONE;
        n_flag_cleared   = 1'b0;
        done_inc         = r_blink_done + 16'd1;

        // event
        case (i_action)
            ACT_TICK: begin
                if (r_wait_left != '0) begin
                    n_wait_left = r_wait_left - 16'd1;
                end
                if (r_pairing_active && (r_pair_elapsed != ElapsedMax)) begin
                    n_pair_elapsed = r_pair_elapsed + 20'd1;
                end
            end
            ACT_FLAG_WRITE: begin
                n_blink_target = {9'd0, i_flag_value[6:0] & CountMask};
                if (i_flag_value[6:0] == '0) begin
                    n_led_color      = COL_GREEN;
                    n_blink_active   = 1'b0;
                    n_warning_active = 1'b0;
                end else begin
                    n_led_color      = i_flag_value[7] ? COL_RED : COL_YELLOW;
                    n_blink_active   = 1'b1;
                    n_warning_active = 1'b1;
                end
            end
            ACT_WARN_BTN: begin
                if (r_warning_active) begin
                    n_blink_active   = 1'b0;
                    n_led_color      = COL_GREEN;
                    n_warning_active = 1'b0;
                    n_flag_cleared   = 1'b1;
                end
            end
            ACT_PAIR_BTN: begin
                if (!r_link_connected) begin
                    n_pairing_active = 1'b1;
                    n_pair_elapsed   = '0;
                    n_led_color      = COL_BLUE;
                    n_blink_target   = PairBlinks;
                    n_blink_active   = 1'b1;
                end
            end
            ACT_CONNECT: begin
                n_pairing_active = 1'b0;
                n_led_color      = COL_GREEN;
                n_blink_active   = 1'b0;
                n_led_lit        = 1'b1;
                n_link_connected = 1'b1;
                n_sound_cue      = CUE_CONNECT;
            end
            ACT_DISCONNECT: begin
                n_led_color      = COL_PURPLE;
                n_blink_active   = 1'b0;
                n_led_lit        = 1'b1;
                n_link_connected = 1'b0;
                n_sound_cue      = CUE_DISCONNECT;
            end
            default: begin
            end
        endcase

        // LED step: steady colour, or toggle when the wait has run out
        done_inc = n_blink_done + 16'd1;
        if (!n_blink_active) begin
            n_shown_color = n_led_color;
        end else if (n_wait_left == '0) begin
            if (n_led_lit) begin
                n_shown_color = COL_OFF;
                n_led_lit     = 1'b0;
                if (done_inc >= n_blink_target) begin
                    n_wait_left  = r_blink_pause;
                    n_blink_done = '0;
                end else begin
                    n_wait_left  = r_blink_interval;
                    n_blink_done = done_inc;
                end
            end else begin
                n_shown_color = n_led_color;
                n_led_lit     = 1'b1;
                n_wait_left   = r_blink_interval;
            end
        end

        // pairing timeout
        if (n_pairing_active && (n_pair_elapsed >= r_pair_timeout)) begin
            n_pairing_active = 1'b0;
            n_led_color      = COL_PURPLE;
            n_blink_active   = 1'b0;
            n_led_lit        = 1'b1;
            n_sound_cue      = CUE_DISCONNECT;
        end

        n_levels = color_levels(n_shown_color);
    end

    // Advance state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_color      <= COL_PURPLE;
            r_shown_color    <= COL_OFF;
            r_blink_active   <= 1'b0;
            r_led_lit        <= 1'b0;
            r_warning_active <= 1'b0;
            r_pairing_active <= 1'b0;
            r_link_connected <= 1'b0;
            r_blink_target   <= '0;
            r_blink_done     <= '0;
            r_wait_left      <= '0;
            r_pair_elapsed   <= '0;
        end else if (in_accept) begin
            r_led_color      <= n_led_color;
            r_shown_color    <= n_shown_color;
            r_blink_active   <= n_blink_active;
            r_led_lit        <= n_led_lit;
            r_warning_active <= n_warning_active;
            r_pairing_active <= n_pairing_active;
            r_link_connected <= n_link_connected;
            r_blink_target   <= n_blink_target;
            r_blink_done     <= n_blink_done;
            r_wait_left      <= n_wait_left;
            r_pair_elapsed   <= n_pair_elapsed;
        end
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_levels       <= n_levels;
            r_advertising  <= n_pairing_active;
            r_sound_cue    <= n_sound_cue;
            r_flag_cleared <= n_flag_cleared;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_red_level    = r_levels.red;
    assign o_green_level  = r_levels.green;
    assign o_blue_level   = r_levels.blue;
    assign o_advertising  = r_advertising;
    assign o_sound_cue    = r_sound_cue;
    assign o_flag_cleared = r_flag_cleared;

    // Pairing is never active while the link is up
    a_pair_not_connected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pairing_active |-> !r_link_connected)
        else $error("pairing active while connected");

    // A connect yields the connect cue and stops advertising
    a_connect_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_action == ACT_CONNECT)) |=>
            (o_out_valid && (o_sound_cue == CUE_CONNECT) && !o_advertising))
        else $error("connect result wrong");

    // Input is only held off by a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result pending");

endmodule

`default_nettype wire
